>>> design/tpdr_pkg.sv
// ----------------------------------------------------------------------------
// tpdr_pkg
// types and constants shared by the teaching pci device register block
// ----------------------------------------------------------------------------
package tpdr_pkg;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 20;
  localparam int SIZE_W = 4;
  localparam int DATA_W = 64;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 6;

  localparam logic [FUNC_W-1:0] FN_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TICK  = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_ID     = 20'h00000;
  localparam logic [ADDR_W-1:0] ADDR_LIVE   = 20'h00004;
  localparam logic [ADDR_W-1:0] ADDR_FACT   = 20'h00008;
  localparam logic [ADDR_W-1:0] ADDR_STATUS = 20'h00020;
  localparam logic [ADDR_W-1:0] ADDR_ISR    = 20'h00024;
  localparam logic [ADDR_W-1:0] ADDR_RAISE  = 20'h00060;
  localparam logic [ADDR_W-1:0] ADDR_LOWER  = 20'h00064;
  localparam logic [ADDR_W-1:0] ADDR_WIDE   = 20'h00080;
  localparam logic [ADDR_W-1:0] ADDR_DMA_SRC = 20'h00080;
  localparam logic [ADDR_W-1:0] ADDR_DMA_DST = 20'h00088;
  localparam logic [ADDR_W-1:0] ADDR_DMA_LEN = 20'h00090;
  localparam logic [ADDR_W-1:0] ADDR_DMA_CMD = 20'h00098;

  localparam logic [SIZE_W-1:0] SIZE_WORD = 4'd4;
  localparam logic [SIZE_W-1:0] SIZE_DWORD = 4'd8;

  localparam logic [WORD_W-1:0] ID_WORD      = 32'h010000ed;
  localparam logic [WORD_W-1:0] FACT_IRQ_BIT = 32'h00000001;
  localparam logic [WORD_W-1:0] DMA_IRQ_BIT  = 32'h00000100;

  localparam int STAT_BUSY_POS  = 0;
  localparam int STAT_IRQEN_POS = 7;
  localparam int CMD_RUN_POS    = 0;
  localparam int CMD_IRQ_POS    = 2;

  // operands at or above this give zero modulo 2^32
  localparam logic [WORD_W-1:0] FACT_LIMIT = 32'd34;

  typedef enum logic {
    S_IDLE,
    S_FACT
  } state_t;

endpackage

>>> design/tpdr_if.sv
// ----------------------------------------------------------------------------
// tpdr channel interfaces
// valid/ready channels for access items and result items
// ----------------------------------------------------------------------------
interface tpdr_in_if
  import tpdr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] reg_addr;
  logic [SIZE_W-1:0] access_size;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, func, reg_addr, access_size, write_data, input ready);
  modport sink   (input valid, func, reg_addr, access_size, write_data, output ready);
endinterface

interface tpdr_out_if
  import tpdr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_level;

  modport source (output valid, read_data, irq_level, input ready);
  modport sink   (input valid, read_data, irq_level, output ready);
endinterface

>>> design/teaching_pci_device_registers_unit.sv
// ----------------------------------------------------------------------------
// teaching_pci_device_registers_unit
// register block of a teaching pci device with an iterative factorial unit
// ----------------------------------------------------------------------------
// in_ch carries one item per handshake: a register read, a register write or
// a tick. out_ch returns exactly one result item per input item, in order,
// holding read_data and the interrupt level after the item.
// Reads, writes and ticks with no pending factorial are accepted and their
// result sits in the output register on the next edge.
// A tick with a pending factorial steps one shared 32 x 6 multiplier once per
// cycle for k = 2..n, with n at most 33, then posts its result once the output
// register is free; the block is not ready while it iterates.
// The output register frees the input side: a new item is accepted while the
// previous result is being taken. If the receiver stalls, the result holds
// and no new item is accepted until the output register is free.
// Synchronous active-low reset clears the device registers to zero, with no
// result pending.
// ----------------------------------------------------------------------------
module teaching_pci_device_registers_unit
  import tpdr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  tpdr_in_if.sink  in_ch,
  tpdr_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic [WORD_W-1:0] live_r, live_nxt;
  logic [WORD_W-1:0] fact_r, fact_nxt;
  logic              computing_r, computing_nxt;
  logic              irq_en_r, irq_en_nxt;
  logic [WORD_W-1:0] isr_r, isr_nxt;
  logic [DATA_W-1:0] dma_src_r, dma_src_nxt;
  logic [DATA_W-1:0] dma_dst_r, dma_dst_nxt;
  logic [DATA_W-1:0] dma_len_r, dma_len_nxt;
  logic [DATA_W-1:0] dma_cmd_r, dma_cmd_nxt;

  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] read_data_r, read_data_nxt;
  logic              irq_r, irq_nxt;

  logic              out_free;
  logic              in_fire;
  logic              fact_done;
  logic              size_ok;
  logic              size_word;
  logic              running;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rd_val;
  logic [WORD_W-1:0] prod;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign fact_done = k_r > n_r;
  assign size_word = in_ch.access_size == SIZE_WORD;
  assign size_ok   = size_word ||
                     (in_ch.reg_addr >= ADDR_WIDE && in_ch.access_size == SIZE_DWORD);
  assign running   = dma_cmd_r[CMD_RUN_POS];
  assign wdata     = size_word ? {32'd0, in_ch.write_data[WORD_W-1:0]} : in_ch.write_data;
  assign prod      = WORD_W'(acc_r * WORD_W'(k_r));

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = read_data_r;
  assign out_ch.irq_level = irq_r;

  // read mux
  always_comb begin
    rd_val = '1;
    if (size_ok) begin
      unique case (in_ch.reg_addr)
        ADDR_ID:      rd_val = {32'd0, ID_WORD};
        ADDR_LIVE:    rd_val = {32'd0, live_r};
        ADDR_FACT:    rd_val = {32'd0, fact_r};
        ADDR_STATUS:  rd_val = {56'd0, irq_en_r, 6'd0, computing_r};
        ADDR_ISR:     rd_val = {32'd0, isr_r};
        ADDR_DMA_SRC: rd_val = dma_src_r;
        ADDR_DMA_DST: rd_val = dma_dst_r;
        ADDR_DMA_LEN: rd_val = dma_len_r;
        ADDR_DMA_CMD: rd_val = dma_cmd_r;
        default:      rd_val = '1;
      endcase
      if (size_word) begin
        rd_val = {32'd0, rd_val[WORD_W-1:0]};
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.func == FN_TICK && computing_r) begin
          state_nxt = S_FACT;
        end
      end
      S_FACT: begin
        if (fact_done && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic load_out;
    load_out      = 1'b0;
    live_nxt      = live_r;
    fact_nxt      = fact_r;
    computing_nxt = computing_r;
    irq_en_nxt    = irq_en_r;
    isr_nxt       = isr_r;
    dma_src_nxt   = dma_src_r;
    dma_dst_nxt   = dma_dst_r;
    dma_len_nxt   = dma_len_r;
    dma_cmd_nxt   = dma_cmd_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    read_data_nxt = read_data_r;
    irq_nxt       = irq_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          read_data_nxt = '0;
          load_out      = 1'b1;
          unique case (in_ch.func)
            FN_READ: read_data_nxt = rd_val;
            FN_WRITE: begin
              if (size_ok) begin
                unique case (in_ch.reg_addr)
                  ADDR_LIVE: live_nxt = ~wdata[WORD_W-1:0];
                  ADDR_FACT: begin
                    if (!computing_r) begin
                      fact_nxt      = wdata[WORD_W-1:0];
                      computing_nxt = 1'b1;
                    end
                  end
                  ADDR_STATUS:  irq_en_nxt = wdata[STAT_IRQEN_POS];
                  ADDR_RAISE:   isr_nxt = isr_r | wdata[WORD_W-1:0];
                  ADDR_LOWER:   isr_nxt = isr_r & ~wdata[WORD_W-1:0];
                  ADDR_DMA_SRC: if (!running) dma_src_nxt = wdata;
                  ADDR_DMA_DST: if (!running) dma_dst_nxt = wdata;
                  ADDR_DMA_LEN: if (!running) dma_len_nxt = wdata;
                  ADDR_DMA_CMD: if (wdata[CMD_RUN_POS] && !running) dma_cmd_nxt = wdata;
                  default: ;
                endcase
              end
            end
            FN_TICK: begin
              if (running) begin
                dma_cmd_nxt[CMD_RUN_POS] = 1'b0;
                if (dma_cmd_r[CMD_IRQ_POS]) begin
                  isr_nxt = isr_r | DMA_IRQ_BIT;
                end
              end
              if (computing_r) begin
                load_out = 1'b0;
                k_nxt    = CNT_W'(2);
                if (fact_r >= FACT_LIMIT) begin
                  acc_nxt = '0;
                  n_nxt   = '0;
                end else begin
                  acc_nxt = WORD_W'(1);
                  n_nxt   = fact_r[CNT_W-1:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FACT: begin
        if (!fact_done) begin
          acc_nxt = prod;
          k_nxt   = k_r + CNT_W'(1);
        end else if (out_free) begin
          fact_nxt      = acc_r;
          computing_nxt = 1'b0;
          if (irq_en_r) begin
            isr_nxt = isr_r | FACT_IRQ_BIT;
          end
          read_data_nxt = '0;
          load_out      = 1'b1;
        end
      end
      default: ;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
      irq_nxt       = |isr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      live_r      <= '0;
      fact_r      <= '0;
      computing_r <= 1'b0;
      irq_en_r    <= 1'b0;
      isr_r       <= '0;
      dma_src_r   <= '0;
      dma_dst_r   <= '0;
      dma_len_r   <= '0;
      dma_cmd_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      live_r      <= live_nxt;
      fact_r      <= fact_nxt;
      computing_r <= computing_nxt;
      irq_en_r    <= irq_en_nxt;
      isr_r       <= isr_nxt;
      dma_src_r   <= dma_src_nxt;
      dma_dst_r   <= dma_dst_nxt;
      dma_len_r   <= dma_len_nxt;
      dma_cmd_r   <= dma_cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    read_data_r <= read_data_nxt;
    irq_r       <= irq_nxt;
  end

`ifndef SYNTH
  a_fact_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FACT |-> computing_r)
    else $error("factorial loop running without a pending operand");

  a_fact_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FACT |->
      (({1'b0, k_r} <= {1'b0, n_r} + 7'd1) || k_r == CNT_W'(2)))
    else $error("factorial counter ran past its operand");

  a_fact_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FACT && fact_done && out_free) |=>
      (!computing_r && out_valid_r && state_r == S_IDLE))
    else $error("factorial finish did not post a result");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !(in_ch.func == FN_TICK && computing_r)) |=> out_valid_r)
    else $error("single-cycle item produced no result");
`endif

endmodule
